### hw/rtl/atsm_pkg.sv
// Package for the affine texture span mapper.
// Holds request codes, controller states, command/status structs and fixed widths.
// No dependencies.
package atsm_pkg;

    localparam int TEXELS     = 4096;
    localparam int TEX_AW     = 12;
    localparam int COORD_LSB  = 20;
    localparam int CRD_BITS   = 6;
    localparam int WIDTH_W    = 7;
    localparam int OFFSET_W   = 6;
    localparam int ROW_IN_W   = 5;
    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [1:0] {
        REQ_LOAD_TEX   = 2'd0,
        REQ_LOAD_LIGHT = 2'd1,
        REQ_SPAN       = 2'd2
    } req_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SPAN = 1'b1
    } state_t;

    typedef struct packed {
        logic load_span;
        logic issue;
        logic write_tex;
        logic write_light;
    } ctrl_cmd_t;

    typedef struct packed {
        logic credit_ok;
        logic last_pixel;
        logic span_nonzero;
    } dp_status_t;

endpackage

### hw/rtl/atsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module atsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/atsm_ctrl.sv
// Controller state machine for the span mapper: input handshake and pixel issue.
// Depends on atsm_pkg.
module atsm_ctrl import atsm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;
    req_t   req;
    logic   accept;

    assign req    = req_t'(s_tuser);
    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (req == REQ_SPAN) && status.span_nonzero) begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN: begin
                if (status.credit_ok && status.last_pixel) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    case (req)
                        REQ_LOAD_TEX:   cmd.write_tex   = 1'b1;
                        REQ_LOAD_LIGHT: cmd.write_light = 1'b1;
                        REQ_SPAN:       cmd.load_span   = status.span_nonzero;
                        default:        cmd             = '0;
                    endcase
                end
            end
            ST_SPAN: begin
                cmd.issue = status.credit_ok;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/atsm_datapath.sv
// Datapath of the span mapper: coordinate walk, texture and colormap stores,
// two-stage lookup pipeline and output buffer. Depends on atsm_pkg and atsm_ram.
module atsm_datapath import atsm_pkg::*; #(
    parameter int MAX_SPAN   = 64,
    parameter int LIGHT_ROWS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [TEX_AW-1:0]    tex_mask,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int LIGHT_DEPTH = LIGHT_ROWS * 256;
    localparam int LA_W        = $clog2(LIGHT_DEPTH);
    localparam int RW          = (LIGHT_ROWS > 1) ? $clog2(LIGHT_ROWS) : 1;

    // Input fields.
    logic [12:0]         in_addr;
    logic [7:0]          in_data;
    logic [31:0]         in_u, in_v, in_du, in_dv;
    logic [WIDTH_W-1:0]  in_width;
    logic [ROW_IN_W-1:0] in_row;
    logic                in_lit, in_trans;

    assign in_addr  = s_tdata[12:0];
    assign in_data  = s_tdata[20:13];
    assign in_u     = s_tdata[52:21];
    assign in_v     = s_tdata[84:53];
    assign in_du    = s_tdata[116:85];
    assign in_dv    = s_tdata[148:117];
    assign in_width = s_tdata[155:149];
    assign in_row   = s_tdata[160:156];
    assign in_lit   = s_tdata[161];
    assign in_trans = s_tdata[162];

    // Span state.
    logic [31:0]        cur_u_reg, cur_u_next, cur_v_reg, cur_v_next;
    logic [31:0]        du_reg, du_next, dv_reg, dv_next;
    logic [WIDTH_W-1:0] left_reg, left_next;
    logic [RW-1:0]      row_reg, row_next;
    logic               lit_reg, lit_next, trans_reg, trans_next;

    // Pipeline stages.
    logic                v1_reg, v1_next, v2_reg, v2_next;
    logic [OFFSET_W-1:0] off1_reg, off1_next, off2_reg, off2_next;
    logic                last1_reg, last1_next, last2_reg, last2_next;
    logic                lit1_reg, lit1_next, lit2_reg, lit2_next;
    logic                trans1_reg, trans1_next, trans2_reg, trans2_next;
    logic [RW-1:0]       row1_reg, row1_next;
    logic [7:0]          texel2_reg, texel2_next;

    // Output buffer.
    logic [M_TDATA_W-1:0] fdata_reg [FIFO_DEPTH];
    logic                 fwe_reg   [FIFO_DEPTH];
    logic                 flast_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next, occupancy;
    logic                 push, pop;

    // Store ports.
    logic [TEX_AW-1:0] tex_raddr;
    logic [7:0]        texel;
    logic              light_we;
    logic [LA_W-1:0]   light_waddr, light_raddr;
    logic [7:0]        light_rdata;
    logic [7:0]        color;
    logic              we_pix;

    assign tex_raddr = {cur_u_reg[COORD_LSB +: CRD_BITS], cur_v_reg[COORD_LSB +: CRD_BITS]}
                       & tex_mask;

    atsm_ram #(.WIDTH(8), .DEPTH(TEXELS), .AW(TEX_AW)) u_tex_ram (
        .aclk  (aclk),
        .we    (cmd.write_tex),
        .waddr (in_addr[TEX_AW-1:0]),
        .wdata (in_data),
        .raddr (tex_raddr),
        .rdata (texel)
    );

    assign light_we    = cmd.write_light && (int'(in_addr[12:8]) < LIGHT_ROWS);
    assign light_waddr = LA_W'({RW'(in_addr[12:8]), in_addr[7:0]});
    assign light_raddr = LA_W'({row1_reg, texel});

    atsm_ram #(.WIDTH(8), .DEPTH(LIGHT_DEPTH), .AW(LA_W)) u_light_ram (
        .aclk  (aclk),
        .we    (light_we),
        .waddr (light_waddr),
        .wdata (in_data),
        .raddr (light_raddr),
        .rdata (light_rdata)
    );

    always_comb begin
        cur_u_next = cur_u_reg;
        cur_v_next = cur_v_reg;
        du_next    = du_reg;
        dv_next    = dv_reg;
        left_next  = left_reg;
        row_next   = row_reg;
        lit_next   = lit_reg;
        trans_next = trans_reg;
        if (cmd.load_span) begin
            cur_u_next = in_u;
            cur_v_next = in_v;
            du_next    = in_du;
            dv_next    = in_dv;
            left_next  = (int'(in_width) > MAX_SPAN) ? WIDTH_W'(MAX_SPAN) : in_width;
            row_next   = (int'(in_row) >= LIGHT_ROWS) ? RW'(LIGHT_ROWS - 1) : RW'(in_row);
            lit_next   = in_lit;
            trans_next = in_trans;
        end else if (cmd.issue) begin
            cur_u_next = cur_u_reg + du_reg;
            cur_v_next = cur_v_reg + dv_reg;
            left_next  = left_reg - WIDTH_W'(1);
        end
    end

    always_comb begin
        v1_next     = cmd.issue;
        off1_next   = OFFSET_W'(left_reg - WIDTH_W'(1));
        last1_next  = (left_reg == WIDTH_W'(1));
        lit1_next   = lit_reg;
        trans1_next = trans_reg;
        row1_next   = row_reg;

        v2_next     = v1_reg;
        off2_next   = off1_reg;
        last2_next  = last1_reg;
        lit2_next   = lit1_reg;
        trans2_next = trans1_reg;
        texel2_next = texel;
    end

    always_comb begin
        we_pix = !(trans2_reg && (texel2_reg == 8'd0));
        if (!we_pix) begin
            color = 8'd0;
        end else if (lit2_reg) begin
            color = light_rdata;
        end else begin
            color = texel2_reg;
        end
    end

    assign push      = v2_reg;
    assign pop       = m_tvalid && m_tready;
    assign occupancy = count_reg + FIFO_CW'(v1_reg) + FIFO_CW'(v2_reg);

    always_comb begin
        wptr_next  = push ? wptr_reg + FIFO_AW'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + FIFO_AW'(1) : rptr_reg;
        count_next = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    assign status.credit_ok    = (occupancy < FIFO_CW'(FIFO_DEPTH));
    assign status.last_pixel   = (left_reg == WIDTH_W'(1));
    assign status.span_nonzero = (in_width != '0);

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = fdata_reg[rptr_reg];
    assign m_tuser  = fwe_reg[rptr_reg];
    assign m_tlast  = flast_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg  <= '0;
            cur_u_reg <= '0;
            cur_v_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            left_reg  <= left_next;
            cur_u_reg <= cur_u_next;
            cur_v_reg <= cur_v_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        du_reg      <= du_next;
        dv_reg      <= dv_next;
        row_reg     <= row_next;
        lit_reg     <= lit_next;
        trans_reg   <= trans_next;
        off1_reg    <= off1_next;
        last1_reg   <= last1_next;
        lit1_reg    <= lit1_next;
        trans1_reg  <= trans1_next;
        row1_reg    <= row1_next;
        off2_reg    <= off2_next;
        last2_reg   <= last2_next;
        lit2_reg    <= lit2_next;
        trans2_reg  <= trans2_next;
        texel2_reg  <= texel2_next;
        if (push) begin
            fdata_reg[wptr_reg] <= M_TDATA_W'({color, off2_reg});
            fwe_reg[wptr_reg]   <= we_pix;
            flast_reg[wptr_reg] <= last2_reg;
        end
    end

endmodule

### hw/rtl/affine_texture_span_mapper.sv
// Affine texture span mapper, top level: APB register, controller and datapath.
// A load transfer is taken whenever the controller is idle. A span of N pixels holds off
// the input until its last pixel issues, one pixel per cycle while the output buffer has room,
// paced by the single read port of the texture and colormap stores and the output buffer.
// Reset (aresetn, synchronous, active low) clears control state and sets the index mask
// to 4095; texture and colormap contents are undefined until written, with no clearing pass.
module affine_texture_span_mapper import atsm_pkg::*; #(
    parameter int MAX_SPAN   = 64,
    parameter int LIGHT_ROWS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // mem_addr, mem_data, u_start, v_start, u_step, v_step, span_width,
    // light_row, use_light, transparent
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_offset, color
    output logic [M_TDATA_W-1:0] m_tdata,
    // write_enable
    output logic                 m_tuser,
    output logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [TEX_AW-1:0] tex_mask_reg, tex_mask_next;
    ctrl_cmd_t         cmd;
    dp_status_t        status;

    assign pready = 1'b1;

    always_comb begin
        tex_mask_next = tex_mask_reg;
        if (psel && penable && pwrite && !paddr[2]) begin
            tex_mask_next = pwdata[TEX_AW-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(tex_mask_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_mask_reg <= TEX_AW'(TEXELS - 1);
        end else begin
            tex_mask_reg <= tex_mask_next;
        end
    end

    atsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    atsm_datapath #(
        .MAX_SPAN   (MAX_SPAN),
        .LIGHT_ROWS (LIGHT_ROWS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .tex_mask (tex_mask_reg),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
